@@ rtl/core/pps_pkg.sv @@
package pps_pkg;

  // Store geometry
  localparam int MaxPoints = 1024;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CntW      = 11;
  localparam int HalfWindow = 20;

  // CORDIC setup
  localparam int CordicSteps = 16;
  localparam int StepW       = 5;
  localparam int CW          = 37;  // x/y datapath width
  localparam int ZW          = 24;  // angle width

  localparam logic signed [ZW-1:0] HalfPiQ = ZW'(102944);
  localparam logic signed [ZW-1:0] PiQ     = ZW'(205887);
  localparam logic signed [ZW-1:0] TwoPiQ  = ZW'(411775);
  localparam logic signed [CW-1:0] InvGain = CW'(39797);

  // Register indexes
  typedef enum logic [1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_LOOKAHEAD   = 2'd1,
    REG_WHEELBASE   = 2'd2
  } reg_idx_e;

  // Distance unit request/response
  typedef struct packed {
    logic               start;
    logic               len_mode;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } dist_req_t;

  typedef struct packed {
    logic        done;
    logic [65:0] sq;
    logic [32:0] len;
  } dist_rsp_t;

  // CORDIC request/response
  typedef struct packed {
    logic                 start;
    logic                 vec;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_rsp_t;

  // atan(2^-i) in Q8.16
  function automatic logic signed [ZW-1:0] atan_tab(input logic [StepW-1:0] i);
    case (i)
      5'd0:    return ZW'(51472);
      5'd1:    return ZW'(30386);
      5'd2:    return ZW'(16055);
      5'd3:    return ZW'(8150);
      5'd4:    return ZW'(4091);
      5'd5:    return ZW'(2047);
      5'd6:    return ZW'(1024);
      5'd7:    return ZW'(512);
      5'd8:    return ZW'(256);
      5'd9:    return ZW'(128);
      5'd10:   return ZW'(64);
      5'd11:   return ZW'(32);
      5'd12:   return ZW'(16);
      5'd13:   return ZW'(8);
      5'd14:   return ZW'(4);
      5'd15:   return ZW'(2);
      5'd16:   return ZW'(1);
      default: return '0;
    endcase
  endfunction

endpackage

@@ rtl/core/pps_path_mem.sv @@
module pps_path_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [pps_pkg::AddrW-1:0]  waddr_i,
  input  logic [63:0]                wdata_i,
  input  logic                       re_i,
  input  logic [pps_pkg::AddrW-1:0]  raddr_i,
  output logic [63:0]                rdata_o
);

  logic [63:0] mem_q [pps_pkg::MaxPoints];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/pps_dist.sv @@
module pps_dist (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pps_pkg::dist_req_t req_i,
  output pps_pkg::dist_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_MUL  = 3'b010,
    D_SQRT = 3'b100
  } dstate_e;

  dstate_e     state_q, state_d;
  logic [2:0]  phase_q;
  logic        len_q;
  logic        done_q;
  logic [32:0] ax_q, ay_q, op;
  logic [16:0] half;
  logic [49:0] prod_q;
  logic        sh_q;
  logic [65:0] sq_q, sq_d;
  logic [63:0] n_q, r_q, bit_q, t, r_n, n_n;
  logic        ge, big_q;
  logic [4:0]  cnt_q;
  logic [32:0] len_out_q;

  // partial product select: 17-bit slice times full operand
  always_comb begin
    op   = phase_q[1] ? ay_q : ax_q;
    half = phase_q[0] ? op[32:16] : {1'b0, op[15:0]};
    sq_d = sq_q + (sh_q ? {prod_q, 16'b0} : {16'b0, prod_q});
  end

  // one restoring square-root step
  always_comb begin
    t   = r_q + bit_q;
    ge  = n_q >= t;
    r_n = ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);
    n_n = ge ? (n_q - t) : n_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      D_IDLE: if (req_i.start) state_d = D_MUL;
      D_MUL:  if (phase_q == 3'd4) state_d = len_q ? D_SQRT : D_IDLE;
      D_SQRT: if (cnt_q == 5'd31) state_d = D_IDLE;
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == D_MUL) && (phase_q == 3'd4) && !len_q) ||
                 ((state_q == D_SQRT) && (cnt_q == 5'd31));
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          ax_q    <= req_i.dx[32] ? 33'(-req_i.dx) : 33'(req_i.dx);
          ay_q    <= req_i.dy[32] ? 33'(-req_i.dy) : 33'(req_i.dy);
          len_q   <= req_i.len_mode;
          phase_q <= '0;
          sq_q    <= '0;
        end
      end
      D_MUL: begin
        if (phase_q != 3'd4) begin
          prod_q <= 50'(half) * 50'(op);
          sh_q   <= phase_q[0];
        end
        if (phase_q != 3'd0) begin
          sq_q <= sq_d;
        end
        phase_q <= phase_q + 3'd1;
        // prepare root operand from the final sum
        if (phase_q == 3'd4) begin
          big_q <= sq_d[65:64] != 2'b00;
          n_q   <= (sq_d[65:64] != 2'b00) ? sq_d[65:2] : sq_d[63:0];
          r_q   <= '0;
          bit_q <= 64'h4000_0000_0000_0000;
          cnt_q <= '0;
        end
      end
      D_SQRT: begin
        n_q   <= n_n;
        r_q   <= r_n;
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          len_out_q <= big_q ? {r_n[31:0], 1'b0} : {1'b0, r_n[31:0]};
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sq   = sq_q;
  assign rsp_o.len  = len_out_q;

endmodule

@@ rtl/core/pps_cordic.sv @@
module pps_cordic (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pps_pkg::cordic_req_t req_i,
  output pps_pkg::cordic_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    C_IDLE = 2'b01,
    C_RUN  = 2'b10
  } cstate_e;

  cstate_e                          state_q, state_d;
  logic signed [pps_pkg::CW-1:0]    x_q, y_q, xs, ys, x_n, y_n;
  logic signed [pps_pkg::ZW-1:0]    z_q, z_n, ang;
  logic [pps_pkg::StepW-1:0]        i_q;
  logic                             vec_q, zero_q, cw, last;
  logic                             done_q;
  logic signed [pps_pkg::CW-1:0]    ry_q;
  logic signed [pps_pkg::ZW-1:0]    rz_q;

  // one micro-rotation
  always_comb begin
    xs   = x_q >>> i_q;
    ys   = y_q >>> i_q;
    ang  = pps_pkg::atan_tab(i_q);
    cw   = vec_q ? (y_q > 0) : (z_q < 0);
    last = i_q == pps_pkg::StepW'(pps_pkg::CordicSteps - 1);
    if (cw) begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + ang;
    end else begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - ang;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE:  if (req_i.start) state_d = C_RUN;
      C_RUN:   if (last) state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == C_RUN) && last;
    end
  end

  // datapath, with quadrant pre-rotation in vectoring mode
  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE) begin
      if (req_i.start) begin
        vec_q  <= req_i.vec;
        i_q    <= '0;
        zero_q <= req_i.vec && (req_i.x == '0) && (req_i.y == '0);
        if (req_i.vec && req_i.x < 0) begin
          if (req_i.y >= 0) begin
            x_q <= req_i.y;
            y_q <= -req_i.x;
            z_q <= pps_pkg::HalfPiQ;
          end else begin
            x_q <= -req_i.y;
            y_q <= req_i.x;
            z_q <= -pps_pkg::HalfPiQ;
          end
        end else begin
          x_q <= req_i.x;
          y_q <= req_i.y;
          z_q <= req_i.z;
        end
      end
    end else begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
      i_q <= i_q + 1'b1;
      if (last) begin
        ry_q <= y_n;
        rz_q <= zero_q ? '0 : z_n;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.y    = ry_q;
  assign rsp_o.z    = rz_q;

endmodule

@@ rtl/core/pure_pursuit_steering.sv @@
// A query runs the nearest search point by point over the window, starts the walk and then
// walks the path segment by segment (both searches use the shared square/root unit), and
// ends with the final CORDIC and root passes.
// An empty path goes straight to the result once accepted; a load is written when accepted.
// Throughput: one transaction at a time; input stalls until the result reaches the output.
// Reset (rst_ni, async low) clears control state and restores the register defaults;
// the point store is not cleared.
module pure_pursuit_steering (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [9:0]         point_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [19:0] heading_i,
  input  logic [9:0]         current_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [17:0] steer_angle_o,
  output logic [9:0]         nearest_index_o,
  output logic [9:0]         lookahead_index_o,
  output logic               status_o
);

  localparam int CntW = pps_pkg::CntW;
  localparam int ZW   = pps_pkg::ZW;
  localparam int CW   = pps_pkg::CW;

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_NRD  = 16'h0002,
    ST_NWT  = 16'h0004,
    ST_NDS  = 16'h0008,
    ST_WRD0 = 16'h0010,
    ST_WWT0 = 16'h0020,
    ST_WCHK = 16'h0040,
    ST_WWT  = 16'h0080,
    ST_WLN  = 16'h0100,
    ST_TAT  = 16'h0200,
    ST_TLD  = 16'h0400,
    ST_WRAP = 16'h0800,
    ST_SIN  = 16'h1000,
    ST_MUL  = 16'h2000,
    ST_FAT  = 16'h4000,
    ST_OUT  = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [CntW-1:0] cnt_q;
  logic [30:0]     la_q, wb_q;

  // query context
  logic signed [31:0]   vx_q, vy_q;
  logic signed [19:0]   hd_q;
  logic [CntW-1:0]      last_q, hi_q, lo_q, i_q, best_q, k_q;
  logic [65:0]          dmin_q;
  logic [34:0]          acc_q;
  logic signed [31:0]   px_q, py_q;
  logic signed [ZW-1:0] alpha_q, fold;
  logic [32:0]          ld_q;
  logic signed [19:0]   s_q;
  logic signed [51:0]   prod;

  // result staging and output register
  logic signed [17:0] res_ang_q;
  logic               res_st_q;
  logic               out_valid_q;
  logic signed [17:0] out_ang_q;
  logic [9:0]         out_near_q, out_look_q;
  logic               out_st_q;

  // memory port
  logic                       mem_we, mem_re;
  logic [pps_pkg::AddrW-1:0]  mem_raddr;
  logic [63:0]                rdata;
  logic signed [31:0]         rd_x, rd_y;

  pps_pkg::dist_req_t   dreq;
  pps_pkg::dist_rsp_t   drsp;
  pps_pkg::cordic_req_t creq;
  pps_pkg::cordic_rsp_t crsp;

  logic in_acc, out_free;
  logic [CntW-1:0] n_w, last_w, c_w, lo_w, hi_w;
  logic [CntW:0]   hi_raw;
  logic signed [ZW-1:0] ang_c;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_x     = rdata[31:0];
  assign rd_y     = rdata[63:32];

  // search window from the query fields
  always_comb begin
    n_w    = (cnt_q > CntW'(pps_pkg::MaxPoints)) ? CntW'(pps_pkg::MaxPoints) : cnt_q;
    last_w = n_w - 1'b1;
    c_w    = (CntW'(current_index_i) > last_w) ? last_w : CntW'(current_index_i);
    lo_w   = (c_w > CntW'(pps_pkg::HalfWindow)) ? c_w - CntW'(pps_pkg::HalfWindow) : '0;
    hi_raw = {1'b0, c_w} + (CntW + 1)'(pps_pkg::HalfWindow - 1);
    hi_w   = (hi_raw > {1'b0, last_w}) ? last_w : hi_raw[CntW-1:0];
    if (hi_w < lo_w) hi_w = lo_w;
  end

  // angle fold into [-pi/2, pi/2]
  always_comb begin
    if (alpha_q > pps_pkg::HalfPiQ) fold = pps_pkg::PiQ - alpha_q;
    else if (alpha_q < -pps_pkg::HalfPiQ) fold = -pps_pkg::PiQ - alpha_q;
    else fold = alpha_q;
  end

  assign prod = $signed({1'b0, wb_q}) * s_q;

  always_comb begin
    if (crsp.z > pps_pkg::HalfPiQ) ang_c = pps_pkg::HalfPiQ;
    else if (crsp.z < -pps_pkg::HalfPiQ) ang_c = -pps_pkg::HalfPiQ;
    else ang_c = crsp.z;
  end

  // sequencer next state and unit requests
  always_comb begin
    state_d   = state_q;
    mem_re    = 1'b0;
    mem_raddr = i_q[pps_pkg::AddrW-1:0];
    dreq      = '0;
    creq      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && req_type_i) state_d = (n_w == '0) ? ST_OUT : ST_NRD;
      end
      ST_NRD: begin
        mem_re  = 1'b1;
        state_d = ST_NWT;
      end
      ST_NWT: begin
        dreq.start = 1'b1;
        dreq.dx    = 33'(rd_x) - 33'(vx_q);
        dreq.dy    = 33'(rd_y) - 33'(vy_q);
        state_d    = ST_NDS;
      end
      ST_NDS: begin
        if (drsp.done) state_d = (i_q == hi_q) ? ST_WRD0 : ST_NRD;
      end
      ST_WRD0: begin
        mem_re    = 1'b1;
        mem_raddr = best_q[pps_pkg::AddrW-1:0];
        state_d   = ST_WWT0;
      end
      ST_WWT0: state_d = ST_WCHK;
      ST_WCHK: begin
        if ((acc_q < 35'(la_q)) && (k_q < last_q)) begin
          mem_re    = 1'b1;
          mem_raddr = pps_pkg::AddrW'(k_q + 1'b1);
          state_d   = ST_WWT;
        end else begin
          creq.start = 1'b1;
          creq.vec   = 1'b1;
          creq.x     = CW'(33'(px_q) - 33'(vx_q));
          creq.y     = CW'(33'(py_q) - 33'(vy_q));
          state_d    = ST_TAT;
        end
      end
      ST_WWT: begin
        dreq.start    = 1'b1;
        dreq.len_mode = 1'b1;
        dreq.dx       = 33'(rd_x) - 33'(px_q);
        dreq.dy       = 33'(rd_y) - 33'(py_q);
        state_d       = ST_WLN;
      end
      ST_WLN: if (drsp.done) state_d = ST_WCHK;
      ST_TAT: begin
        if (crsp.done) begin
          dreq.start    = 1'b1;
          dreq.len_mode = 1'b1;
          dreq.dx       = 33'(px_q) - 33'(vx_q);
          dreq.dy       = 33'(py_q) - 33'(vy_q);
          state_d       = ST_TLD;
        end
      end
      ST_TLD: if (drsp.done) state_d = ST_WRAP;
      ST_WRAP: begin
        if (alpha_q <= pps_pkg::PiQ && alpha_q >= -pps_pkg::PiQ) begin
          creq.start = 1'b1;
          creq.x     = pps_pkg::InvGain;
          creq.z     = fold;
          state_d    = ST_SIN;
        end
      end
      ST_SIN: if (crsp.done) state_d = ST_MUL;
      ST_MUL: begin
        creq.start = 1'b1;
        creq.vec   = 1'b1;
        creq.x     = CW'({1'b0, ld_q});
        creq.y     = CW'(prod >>> 15);
        state_d    = ST_FAT;
      end
      ST_FAT: if (crsp.done) state_d = ST_OUT;
      ST_OUT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      la_q        <= 31'd131072;
      wb_q        <= 31'd65536;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pps_pkg::REG_POINT_COUNT: cnt_q <= cfg_wdata_i[CntW-1:0];
          pps_pkg::REG_LOOKAHEAD:   la_q  <= cfg_wdata_i;
          pps_pkg::REG_WHEELBASE:   wb_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // query datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && req_type_i) begin
          vx_q      <= pos_x_i;
          vy_q      <= pos_y_i;
          hd_q      <= heading_i;
          last_q    <= last_w;
          lo_q      <= lo_w;
          hi_q      <= hi_w;
          i_q       <= lo_w;
          best_q    <= '0;
          k_q       <= '0;
          res_ang_q <= '0;
          res_st_q  <= n_w == '0;
        end
      end
      ST_NDS: begin
        if (drsp.done) begin
          if (i_q == lo_q || drsp.sq < dmin_q) begin
            dmin_q <= drsp.sq;
            best_q <= i_q;
          end
          i_q <= i_q + 1'b1;
        end
      end
      ST_WRD0: begin
        k_q   <= best_q;
        acc_q <= '0;
      end
      ST_WWT0: begin
        px_q <= rd_x;
        py_q <= rd_y;
      end
      ST_WCHK: begin
        if ((acc_q < 35'(la_q)) && (k_q < last_q)) k_q <= k_q + 1'b1;
      end
      ST_WLN: begin
        if (drsp.done) begin
          acc_q <= acc_q + 35'(drsp.len);
          px_q  <= rd_x;
          py_q  <= rd_y;
        end
      end
      ST_TAT: if (crsp.done) alpha_q <= crsp.z - ZW'(hd_q);
      ST_TLD: if (drsp.done) ld_q <= drsp.len;
      ST_WRAP: begin
        if (alpha_q > pps_pkg::PiQ) alpha_q <= alpha_q - pps_pkg::TwoPiQ;
        else if (alpha_q < -pps_pkg::PiQ) alpha_q <= alpha_q + pps_pkg::TwoPiQ;
      end
      ST_SIN: if (crsp.done) s_q <= crsp.y[19:0];
      ST_FAT: if (crsp.done) res_ang_q <= ang_c[17:0];
      ST_OUT: begin
        if (out_free) begin
          out_ang_q  <= res_ang_q;
          out_near_q <= best_q[9:0];
          out_look_q <= k_q[9:0];
          out_st_q   <= res_st_q;
        end
      end
      default: ;
    endcase
  end

  assign mem_we = in_acc && !req_type_i &&
                  (CntW'(point_index_i) < CntW'(pps_pkg::MaxPoints));

  pps_path_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pps_pkg::AddrW'(point_index_i)),
    .wdata_i ({pos_y_i, pos_x_i}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  pps_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  pps_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .rsp_o  (crsp)
  );

  assign in_stall_o        = state_q != ST_IDLE;
  assign out_valid_o       = out_valid_q;
  assign steer_angle_o     = out_ang_q;
  assign nearest_index_o   = out_near_q;
  assign lookahead_index_o = out_look_q;
  assign status_o          = out_st_q;

`ifndef SYNTHESIS
  a_nearest_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRD0) |-> (best_q >= lo_q && best_q <= hi_q))
    else $error("nearest index outside search window");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WCHK) |-> (k_q <= last_q))
    else $error("lookahead index past last point");

  a_dist_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |-> (state_q == ST_NDS || state_q == ST_WLN || state_q == ST_TLD))
    else $error("distance result with no consumer");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not presented");
`endif

endmodule

@@ sim/tb_pure_pursuit_steering.sv @@
module tb_pure_pursuit_steering;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  localparam longint CycleLimit = 3_000_000;
  localparam int     MaxInt = 2147483647;
  localparam int     MinInt = -2147483647 - 1;
  localparam int     FillPoints = 96;

  // atan(2^-i), Q16.16
  localparam int AtanStep[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                  256, 128, 64, 32, 16, 8, 4, 2};

  typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic signed [17:0] angle;
    logic [9:0]         near;
    logic [9:0]         target;
    logic               empty;
  } steer_t;

  typedef struct {
    row_kind_e kind;
    int        idx;
    int        x;
    int        y;
    int        hd;
    int        cur;
    bit        typed;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [30:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = 1'b0;
  logic [9:0]         point_index_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [19:0] heading_i = '0;
  logic [9:0]         current_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [17:0] steer_angle_o;
  logic [9:0]         nearest_index_o;
  logic [9:0]         lookahead_index_o;
  logic               status_o;

  pure_pursuit_steering i_dut (.*);

  always #6 clk_i = ~clk_i;

  // Shadow of the block: path store and registers
  int          path_x[pps_pkg::MaxPoints];
  int          path_y[pps_pkg::MaxPoints];
  bit          written[pps_pkg::MaxPoints];
  logic [10:0] count_r;
  logic [30:0] look_r;
  logic [30:0] wheel_r;

  steer_t steer_q[$];
  int     errors = 0;
  int     n_queries = 0;
  int     n_loads = 0;
  int     n_checked = 0;
  bit     quiet = 0;
  longint cycles = 0;

  // Exact squared distance, up to 65 bits
  function automatic logic [65:0] dist_sq(longint dx, longint dy);
    logic [63:0] ax, ay;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    return {2'b0, ax * ax} + {2'b0, ay * ay};
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint seg_len(longint dx, longint dy);
    logic [65:0] s;
    s = dist_sq(dx, dy);
    if (s[65:64] != 0) return longint'(2 * int_sqrt(s[65:2]));
    return longint'(int_sqrt(s[63:0]));
  endfunction

  // Vectoring CORDIC, pre-rotated for negative x
  function automatic longint vec_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = pps_pkg::HalfPiQ;
      end else begin
        x = -y; y = t; z = -pps_pkg::HalfPiQ;
      end
    end
    for (int i = 0; i < pps_pkg::CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += AtanStep[i];
      end else begin
        x -= ys; y += xs; z -= AtanStep[i];
      end
    end
    return z;
  endfunction

  // Rotation CORDIC sine after wrap and fold
  function automatic longint rot_sine(longint a);
    longint x, y, xs, ys;
    x = pps_pkg::InvGain;
    y = 0;
    while (a > pps_pkg::PiQ) a -= pps_pkg::TwoPiQ;
    while (a < -pps_pkg::PiQ) a += pps_pkg::TwoPiQ;
    if (a > pps_pkg::HalfPiQ) a = pps_pkg::PiQ - a;
    if (a < -pps_pkg::HalfPiQ) a = -pps_pkg::PiQ - a;
    for (int i = 0; i < pps_pkg::CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (a >= 0) begin
        x -= ys; y += xs; a -= AtanStep[i];
      end else begin
        x += ys; y -= xs; a += AtanStep[i];
      end
    end
    return y;
  endfunction

  // Expected answer; miss flags a query that would touch a slot never loaded
  function automatic steer_t steer_of(int vx_i, int vy_i, int hd_i, int cur_i,
                                      output bit miss);
    steer_t r;
    longint n, c, lo, hi, best, k, acc, vx, vy, tx, ty, alpha, num, ang, ld;
    logic [65:0] dmin, d;
    r = '0;
    miss = 1'b0;
    n = count_r > pps_pkg::MaxPoints ? pps_pkg::MaxPoints : count_r;
    if (n == 0) begin
      r.empty = 1'b1;
      return r;
    end
    vx = vx_i;
    vy = vy_i;
    c = cur_i;
    if (c > n - 1) c = n - 1;
    lo = c > pps_pkg::HalfWindow ? c - pps_pkg::HalfWindow : 0;
    hi = c + pps_pkg::HalfWindow - 1;
    if (hi > n - 1) hi = n - 1;
    if (hi < lo) hi = lo;
    // nearest point, first strict minimum
    best = lo;
    dmin = dist_sq(path_x[lo] - vx, path_y[lo] - vy);
    for (longint i = lo + 1; i <= hi; i++) begin
      d = dist_sq(path_x[i] - vx, path_y[i] - vy);
      if (d < dmin) begin
        dmin = d; best = i;
      end
    end
    // walk forward along the path
    k = best;
    acc = 0;
    while (acc < longint'(look_r) && k < n - 1) begin
      k++;
      acc += seg_len(longint'(path_x[k]) - path_x[k-1], longint'(path_y[k]) - path_y[k-1]);
    end
    for (longint i = lo; i <= hi; i++) if (!written[i]) miss = 1'b1;
    for (longint i = best; i <= k; i++) if (!written[i]) miss = 1'b1;
    tx = path_x[k] - vx;
    ty = path_y[k] - vy;
    alpha = vec_angle(ty, tx) - hd_i;
    ld = seg_len(tx, ty);
    num = (longint'(wheel_r) * rot_sine(alpha)) >>> 15;
    ang = vec_angle(num, ld);
    if (ang > pps_pkg::HalfPiQ) ang = pps_pkg::HalfPiQ;
    if (ang < -pps_pkg::HalfPiQ) ang = -pps_pkg::HalfPiQ;
    r.angle  = ang[17:0];
    r.near   = best[9:0];
    r.target = k[9:0];
    return r;
  endfunction

  // Drive one transaction and wait for it to be taken
  task automatic send_item(logic rt, int idx, int x, int y, int hd, int cur);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_type_i      <= rt;
    point_index_i   <= idx[9:0];
    pos_x_i         <= x;
    pos_y_i         <= y;
    heading_i       <= hd[19:0];
    current_index_i <= cur[9:0];
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic load_point(int idx, int x, int y);
    send_item(REQ_LOAD, idx, x, y, $urandom_range(0, 411775 * 2) - 411775, $urandom());
    path_x[idx]  = x;
    path_y[idx]  = y;
    written[idx] = 1'b1;
    n_loads++;
  endtask

  // A query that would read a never loaded slot is not sent
  task automatic query(int x, int y, int hd, int cur);
    steer_t e;
    bit     miss;
    e = steer_of(x, y, hd, cur, miss);
    if (miss) return;
    send_item(REQ_QUERY, $urandom(), x, y, hd, cur);
    steer_q.push_back(e);
    n_queries++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (steer_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(pps_pkg::reg_idx_e idx, logic [30:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pps_pkg::REG_POINT_COUNT: count_r = val[10:0];
      pps_pkg::REG_LOOKAHEAD:   look_r  = val;
      pps_pkg::REG_WHEELBASE:   wheel_r = val;
      default: ;
    endcase
  endtask

  // Result side: random stall per transaction
  int stall_left = 0;
  always @(posedge clk_i) begin
    int d;
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end else if (out_valid_o && !out_stall_i) begin
      d = quiet ? 0 : $urandom_range(0, 5);
      stall_left  <= d;
      out_stall_i <= (d > 0);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    steer_t exp_r, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{steer_angle_o, nearest_index_o, lookahead_index_o, status_o};
      if (steer_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
      end else begin
        exp_r = steer_q.pop_front();
        n_checked++;
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp angle %0d near %0d target %0d empty %0b, got %0d %0d %0d %0b",
                     exp_r.angle, exp_r.near, exp_r.target, exp_r.empty,
                     got.angle, got.near, got.target, got.empty);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  row_t dir_rows[19];

  initial begin
    int x, y, n, j, cur, hd;
    int counts[10] = '{96, 2047, 1, 2, 21, 40, 60, 1024, 80, 96};

    count_r = 0;
    look_r  = 131072;
    wheel_r = 65536;

    dir_rows = '{
      '{ROW_QUERY, 0, MaxInt, MinInt, 411775, 1023, 1},
      '{ROW_QUERY, 0, MinInt, MaxInt, -411775, 0, 1},
      '{ROW_LOAD, 0, 0, 0, 0, 0, 0},
      '{ROW_LOAD, 1, 196608, 0, 0, 0, 0},
      '{ROW_LOAD, 2, MinInt, MaxInt, 0, 0, 0},
      '{ROW_LOAD, 3, MaxInt, MinInt, 0, 0, 0},
      '{ROW_CFG, pps_pkg::REG_POINT_COUNT, 4, 0, 0, 0, 0},
      '{ROW_CFG, pps_pkg::REG_LOOKAHEAD, 0, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0},
      '{ROW_QUERY, 0, MinInt, MinInt, 411775, 1023, 0},
      '{ROW_CFG, pps_pkg::REG_LOOKAHEAD, MaxInt, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 65536, 65536, -411775, 0, 0},
      '{ROW_CFG, pps_pkg::REG_WHEELBASE, 0, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 0, -65536, 0, 2, 0},
      '{ROW_CFG, pps_pkg::REG_WHEELBASE, MaxInt, 0, 0, 0, 0},
      '{ROW_QUERY, 0, -65536, 0, 205887, 1, 0},
      '{ROW_CFG, pps_pkg::REG_POINT_COUNT, 1, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 100, 100, 0, 512, 0},
      '{ROW_CFG, pps_pkg::REG_POINT_COUNT, 0, 0, 0, 0, 0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; empty-path answers are known outright
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_LOAD:  load_point(dir_rows[i].idx, dir_rows[i].x, dir_rows[i].y);
        ROW_CFG:   write_reg(pps_pkg::reg_idx_e'(dir_rows[i].idx), dir_rows[i].x[30:0]);
        ROW_QUERY: begin
          if (dir_rows[i].typed) begin
            send_item(REQ_QUERY, 0, dir_rows[i].x, dir_rows[i].y, dir_rows[i].hd,
                      dir_rows[i].cur);
            steer_q.push_back('{18'sd0, 10'd0, 10'd0, 1'b1});
            n_queries++;
          end else begin
            query(dir_rows[i].x, dir_rows[i].y, dir_rows[i].hd, dir_rows[i].cur);
          end
        end
        default: ;
      endcase
    end
    drain();

    // Fill the front of the store with a winding path and a few wild jumps
    x = 0;
    y = 0;
    for (int i = 0; i < FillPoints; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        x = $urandom();
        y = $urandom();
      end else begin
        x += $urandom_range(0, 3 << 16) - (1 << 16);
        y += $urandom_range(0, 3 << 16) - (1 << 16);
      end
      load_point(i, x, y);
    end

    // Random phases over several register settings
    for (int p = 0; p < 10; p++) begin
      write_reg(pps_pkg::REG_POINT_COUNT, 31'(counts[p]));
      if (p == 3 || p == 9) write_reg(pps_pkg::REG_LOOKAHEAD, 31'(MaxInt));
      else if (p == 5) write_reg(pps_pkg::REG_LOOKAHEAD, '0);
      else write_reg(pps_pkg::REG_LOOKAHEAD,
                     31'($urandom_range(0, (p % 2) ? (1 << 17) : (1 << 19))));
      if (p == 1) write_reg(pps_pkg::REG_WHEELBASE, '0);
      else if (p == 2) write_reg(pps_pkg::REG_WHEELBASE, 31'(MaxInt));
      else write_reg(pps_pkg::REG_WHEELBASE, 31'($urandom_range(1 << 15, 4 << 16)));
      quiet = (p == 4 || p == 7);
      n = counts[p] > FillPoints ? FillPoints : counts[p];
      for (int k = 0; k < ((p == 9) ? 3 : 18); k++) begin
        if (p == 5 && k == 15) drain();
        hd = $urandom_range(0, 411775 * 2) - 411775;
        case ($urandom_range(0, 7))
          0: begin
            j = $urandom_range(1, FillPoints - 1);
            load_point(j, path_x[j-1] + $urandom_range(0, 1 << 17) - (1 << 16),
                       path_y[j-1] + $urandom_range(0, 1 << 17) - (1 << 16));
          end
          1: query($urandom(), $urandom(), hd, $urandom_range(0, 1023));
          default: begin
            j = $urandom_range(0, n - 1);
            cur = j + $urandom_range(0, 40) - 20;
            if (cur < 0) cur = 0;
            if (cur > 1023) cur = 1023;
            query(path_x[j] + $urandom_range(0, 1 << 17) - (1 << 16),
                  path_y[j] + $urandom_range(0, 1 << 17) - (1 << 16), hd, cur);
          end
        endcase
      end
      drain();
    end
    quiet = 0;

    $display("covered %0d path loads and %0d steering queries, %0d results compared",
             n_loads, n_queries, n_checked);
    $display("point counts from empty to beyond the store, lookahead and wheelbase extremes");
    if (errors == 0 && steer_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
